// ===== rtl/blf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blf_pkg: shared definitions for the line-drawing framebuffer
// Screen size defaults, coordinate widths, item kinds and the status record
// passed from the line rasteriser to the controller.
// ----------------------------------------------------------------------------
package blf_pkg;

    // Default screen geometry
    localparam int DEFAULT_SCREEN_WIDTH  = 128;
    localparam int DEFAULT_SCREEN_HEIGHT = 64;

    // Pixels stacked in one framebuffer byte
    localparam int PAGE_ROWS  = 8;
    localparam int PAGE_SHIFT = $clog2(PAGE_ROWS);

    // Coordinate widths: input, working (one bit of headroom), error term
    localparam int COORD_W = 11;
    localparam int PIX_W   = 12;
    localparam int ERR_W   = 13;

    // Item kinds
    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Fill patterns
    localparam logic [7:0] FILL_SET   = 8'hFF;
    localparam logic [7:0] FILL_CLEAR = 8'h00;

    // Current pixel from the rasteriser
    typedef struct packed {
        logic                    pix_valid;
        logic                    last;
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
    } raster_status_t;

endpackage
`default_nettype wire

// ===== rtl/blf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module blf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/blf_raster.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blf_raster: Bresenham line stepper
// Setup steps (steep swap on start, endpoint ordering, then error init), then
// one pixel per advance pulse until the end column has been stepped.
// ----------------------------------------------------------------------------
module blf_raster (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [blf_pkg::COORD_W-1:0]    x_start,
    input  wire logic signed [blf_pkg::COORD_W-1:0]    y_start,
    input  wire logic signed [blf_pkg::COORD_W-1:0]    x_end,
    input  wire logic signed [blf_pkg::COORD_W-1:0]    y_end,
    input  wire logic                                  advance,
    output blf_pkg::raster_status_t                    status
);
    import blf_pkg::*;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_SWAP,
        RS_ORDER,
        RS_RUN
    } rs_state_t;

    rs_state_t               state_reg;
    logic                    steep_reg;
    logic signed [PIX_W-1:0] a_u_reg, a_v_reg, b_u_reg, b_v_reg;
    logic signed [PIX_W-1:0] u_reg, v_reg, u_end_reg, dx_reg, dy_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic                    up_reg;

    // Steepness test on the raw endpoints
    logic signed [PIX_W-1:0] dx_raw, dy_raw;
    logic        [PIX_W-1:0] dx_mag, dy_mag;
    logic                    steep;

    always_comb
    begin
        dx_raw = PIX_W'(x_end) - PIX_W'(x_start);
        dy_raw = PIX_W'(y_end) - PIX_W'(y_start);
        dx_mag = dx_raw[PIX_W-1] ? PIX_W'(-dx_raw) : PIX_W'(dx_raw);
        dy_mag = dy_raw[PIX_W-1] ? PIX_W'(-dy_raw) : PIX_W'(dy_raw);
        steep  = dy_mag > dx_mag;
    end

    // Endpoint ordering along the major axis
    logic                    swap_ends;
    logic signed [PIX_W-1:0] lo_u, lo_v, hi_u, hi_v, dv_raw, dv_mag;

    always_comb
    begin
        swap_ends = a_u_reg > b_u_reg;
        lo_u      = swap_ends ? b_u_reg : a_u_reg;
        lo_v      = swap_ends ? b_v_reg : a_v_reg;
        hi_u      = swap_ends ? a_u_reg : b_u_reg;
        hi_v      = swap_ends ? a_v_reg : b_v_reg;
        dv_raw    = hi_v - lo_v;
        dv_mag    = dv_raw[PIX_W-1] ? -dv_raw : dv_raw;
    end

    // Error update for one step
    logic signed [ERR_W-1:0] err_sub, err_step;
    logic                    minor_step;

    always_comb
    begin
        err_sub    = err_reg - ERR_W'(dy_reg);
        minor_step = err_sub[ERR_W-1];
        err_step   = minor_step ? err_sub + ERR_W'(dx_reg) : err_sub;
    end

    // Sequencer and Bresenham state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
        end
        else
        begin
            unique case (state_reg)
                RS_IDLE:
                begin
                    if (start)
                    begin
                        steep_reg <= steep;
                        a_u_reg   <= steep ? PIX_W'(y_start) : PIX_W'(x_start);
                        a_v_reg   <= steep ? PIX_W'(x_start) : PIX_W'(y_start);
                        b_u_reg   <= steep ? PIX_W'(y_end)   : PIX_W'(x_end);
                        b_v_reg   <= steep ? PIX_W'(x_end)   : PIX_W'(y_end);
                        state_reg <= RS_SWAP;
                    end
                end
                RS_SWAP:
                begin
                    u_reg     <= lo_u;
                    v_reg     <= lo_v;
                    u_end_reg <= hi_u;
                    dx_reg    <= hi_u - lo_u;
                    dy_reg    <= dv_mag;
                    up_reg    <= lo_v < hi_v;
                    state_reg <= RS_ORDER;
                end
                RS_ORDER:
                begin
                    // error starts at half the major extent
                    err_reg   <= ERR_W'(dx_reg >>> 1);
                    state_reg <= RS_RUN;
                end
                RS_RUN:
                begin
                    if (advance)
                    begin
                        if (u_reg == u_end_reg)
                        begin
                            state_reg <= RS_IDLE;
                        end
                        else
                        begin
                            u_reg   <= u_reg + PIX_W'(1);
                            err_reg <= err_step;
                            if (minor_step)
                            begin
                                v_reg <= up_reg ? v_reg + PIX_W'(1) : v_reg - PIX_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= RS_IDLE;
                end
            endcase
        end
    end

    // Current pixel in screen axes
    always_comb
    begin
        status.pix_valid = state_reg == RS_RUN;
        status.last      = u_reg == u_end_reg;
        status.px        = steep_reg ? v_reg : u_reg;
        status.py        = steep_reg ? u_reg : v_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/bresenham_line_framebuffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_framebuffer: 1-bpp page-organised framebuffer with line draw
// Draws Bresenham lines pixel by pixel through read-modify-write of the frame
// RAM, fills the whole frame, and reads single bytes back for refresh.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata                               | tuser
//  s_*     | in        | x/y start, x/y end, color, byte_adr | kind
//  m_*     | out       | read_data, pixels_written           | -
//
//  Line: an on-screen pixel is a RAM read then a write on the one frame RAM,
//  an off-screen pixel is stepped past without RAM access; setup comes first.
//  Fill: one byte written per cycle. Read: one registered RAM read, then result.
//  After reset a clearing pass over all FRAME_BYTES zeroes the RAM; no item
//  is taken meanwhile. One item at a time; a finished result waits in the
//  output register while the next item is accepted and worked on.
// ----------------------------------------------------------------------------
module bresenham_line_framebuffer #(
    parameter int SCREEN_WIDTH  = blf_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = blf_pkg::DEFAULT_SCREEN_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [10:0] x_start, [21:11] y_start, [32:22] x_end, [43:33] y_end,
    // [44] color, [54:45] byte_address, [55] zero
    input  wire logic [55:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] read_data, [15:8] pixels_written
    output logic [15:0]      m_tdata
);
    import blf_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_BYTES - 1);
    localparam logic signed [PIX_W-1:0] WIDTH_S  = PIX_W'(SCREEN_WIDTH);
    localparam logic signed [PIX_W-1:0] HEIGHT_S = PIX_W'(SCREEN_HEIGHT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_PLOT,
        ST_WRITE,
        ST_RESULT
    } state_t;

    // Input fields
    logic signed [COORD_W-1:0] x_start, y_start, x_end, y_end;
    logic                      color;
    logic [9:0]                byte_address;
    logic [1:0]                kind;

    assign x_start      = s_tdata[10:0];
    assign y_start      = s_tdata[21:11];
    assign x_end        = s_tdata[32:22];
    assign y_end        = s_tdata[43:33];
    assign color        = s_tdata[44];
    assign byte_address = s_tdata[54:45];
    assign kind         = s_tuser;

    state_t              state_reg;
    logic [ADDR_W-1:0]   sweep_reg;
    logic [7:0]          fill_byte_reg;
    logic                color_reg;
    logic                read_ok_reg;
    logic                last_reg;
    logic [ADDR_W-1:0]   pix_addr_reg;
    logic [7:0]          mask_reg;
    logic [7:0]          data_reg;
    logic [7:0]          count_reg;

    logic                in_xfer;
    logic                read_in_range;
    raster_status_t      rstat;
    logic                raster_start, raster_advance;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;

    assign s_tready      = state_reg == ST_IDLE;
    assign in_xfer       = s_tvalid && s_tready;
    assign read_in_range = 32'(byte_address) < FRAME_BYTES;

    // Pixel bounds, byte address and bit mask
    logic              pix_in;
    logic [ADDR_W-1:0] pix_addr;
    logic [7:0]        pix_mask;

    always_comb
    begin
        pix_in = !rstat.px[PIX_W-1] && !rstat.py[PIX_W-1]
                 && (rstat.px < WIDTH_S) && (rstat.py < HEIGHT_S);
        pix_addr = ADDR_W'(32'(rstat.px[PIX_W-2:0])
                   + 32'(rstat.py[PIX_W-2:PAGE_SHIFT]) * SCREEN_WIDTH);
        pix_mask = 8'(1) << rstat.py[PAGE_SHIFT-1:0];
    end

    // Line rasteriser
    assign raster_start   = in_xfer && (kind == KIND_LINE);
    assign raster_advance = (state_reg == ST_PLOT) && rstat.pix_valid;

    blf_raster u_raster (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (raster_start),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .advance (raster_advance),
        .status  (rstat)
    );

    // Frame RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = fill_byte_reg;
        ram_re    = 1'b0;
        ram_raddr = pix_addr;
        unique case (state_reg)
            ST_CLEAR, ST_FILL:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                ram_re    = in_xfer && (kind == KIND_READ) && read_in_range;
                ram_raddr = ADDR_W'(byte_address);
            end
            ST_PLOT:
            begin
                ram_re = rstat.pix_valid && pix_in;
            end
            ST_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = pix_addr_reg;
                ram_wdata = color_reg ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    blf_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Controller and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            fill_byte_reg <= FILL_CLEAR;
            m_tvalid      <= 1'b0;
        end
        else
        begin
            // load a finished result, drop the held one once transferred
            if ((state_reg == ST_RESULT) && (!m_tvalid || m_tready))
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    sweep_reg <= sweep_reg + ADDR_W'(1);
                    if (sweep_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        data_reg  <= 8'h00;
                        count_reg <= 8'h00;
                        color_reg <= color;
                        unique case (kind)
                            KIND_LINE:
                            begin
                                state_reg <= ST_PLOT;
                            end
                            KIND_FILL:
                            begin
                                fill_byte_reg <= color ? FILL_SET : FILL_CLEAR;
                                sweep_reg     <= '0;
                                state_reg     <= ST_FILL;
                            end
                            KIND_READ:
                            begin
                                read_ok_reg <= read_in_range;
                                state_reg   <= ST_READ;
                            end
                            default:
                            begin
                                state_reg <= ST_RESULT;
                            end
                        endcase
                    end
                end
                ST_FILL:
                begin
                    sweep_reg <= sweep_reg + ADDR_W'(1);
                    if (sweep_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_READ:
                begin
                    data_reg  <= read_ok_reg ? ram_rdata : 8'h00;
                    state_reg <= ST_RESULT;
                end
                ST_PLOT:
                begin
                    // wait through rasteriser setup, then one pixel per visit
                    if (rstat.pix_valid)
                    begin
                        last_reg     <= rstat.last;
                        pix_addr_reg <= pix_addr;
                        mask_reg     <= pix_mask;
                        if (pix_in)
                        begin
                            state_reg <= ST_WRITE;
                        end
                        else if (rstat.last)
                        begin
                            state_reg <= ST_RESULT;
                        end
                    end
                end
                ST_WRITE:
                begin
                    if (count_reg != 8'hFF)
                    begin
                        count_reg <= count_reg + 8'd1;
                    end
                    state_reg <= last_reg ? ST_RESULT : ST_PLOT;
                end
                ST_RESULT:
                begin
                    if (!m_tvalid || m_tready)
                    begin
                        m_tdata   <= {count_reg, data_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // No item is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("item accepted during clearing pass");

    // A pixel write goes to the byte read in the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |-> $past(ram_re) && ($past(ram_raddr) == ram_waddr))
        else $error("pixel write does not match preceding read");

    // The rasteriser only runs while the controller is plotting
    assert property (@(posedge clk) disable iff (!rst_n)
        rstat.pix_valid |-> (state_reg == ST_PLOT) || (state_reg == ST_WRITE))
        else $error("rasteriser active outside a line item");

    // Every RAM write stays inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> 32'(ram_waddr) < FRAME_BYTES)
        else $error("frame RAM write out of range");

endmodule
`default_nettype wire
